@@ rtl/bike_pkg.sv @@
// Shared types, constants and constant functions of the kij estimator.
`default_nettype none

package bike_pkg;

  // Width of a Q0.32 value that may also hold exactly 1.0.
  localparam int QW = 33;
  // Width of a Q6.32 log magnitude (integer part up to 32 needs six bits).
  localparam int NLW = 38;

  localparam logic [QW-1:0] ONE_Q32 = 33'h1_0000_0000;
  // Gao exponent 0.30740130869870384801 in Q0.32, rounded.
  localparam logic [30:0] GAO_EXP_Q32 = 31'd1320278568;

  // Correlation select codes.
  localparam logic OP_CP  = 1'b0;
  localparam logic OP_GAO = 1'b1;

  // Per-item tag that rides along with the datapath.
  typedef struct packed {
    logic op;
    logic inv;
  } bike_tag_t;

  // Bit-by-bit integer square root of a 64-bit value.
  function automatic logic [63:0] bike_isqrt(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = x;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-n) in Q0.32, built by n repeated square roots of one half.
  function automatic logic [31:0] bike_root(input int n);
    logic [63:0] d;
    d = 64'h8000_0000;
    for (int k = 0; k < 32; k++) begin
      if (k < n) begin
        d = bike_isqrt({d[31:0], 32'h0});
      end
    end
    return d[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/bike_if.sv @@
// Stream interfaces for the component pair input and the kij result output.
`default_nettype none

interface bike_pair_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] first_property;
  logic [31:0] second_property;

  modport source (output valid, output op, output first_property,
                  output second_property, input ready);
  modport sink (input valid, input op, input first_property,
                input second_property, output ready);
endinterface

interface bike_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] kij;
  logic        invalid;

  modport source (output valid, output kij, output invalid, input ready);
  modport sink (input valid, input kij, input invalid, output ready);
endinterface

`default_nettype wire

@@ rtl/binary_interaction_kij_estimator_core.sv @@
// Top level of the binary interaction parameter (kij) estimator pipeline.
//
// The block takes one component pair per clock while the pipeline advances and returns
// one kij per pair, in order. Mode 0 applies the Chueh-Prausnitz correlation to critical
// volumes, mode 1 the Gao correlation to critical temperatures; both depend only on the
// ratio r = min/max of the two properties, so the binary point of the inputs does not
// matter. kij is unsigned Q0.32 and saturates at all ones; if either property is zero,
// invalid is set and kij is zero. The pipeline moves as one: it advances whenever the
// output register is empty or its result is being taken, so pair.ready follows
// result.ready combinationally and a full pipeline under backpressure holds every item
// in place. The pipeline is these units in series, with their stage counts: ratio divider
// (33), log (39), divide by k (6), power of two (34), h^2 and denominator (2), second
// divider (33), cube (2), log (39), exponent scaling (1), power of two (34), plus the
// input and output registers.
`default_nettype none

module binary_interaction_kij_estimator_core import bike_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bike_pair_if.sink     pair,
  bike_result_if.source result
);

  localparam int TAGW = $bits(bike_tag_t);
  localparam int SW2  = TAGW + QW;

  // The whole pipeline advances together; the output register is the last stage.
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign pair.ready = adv;

  // Input stage: order the pair and flag a zero property.
  logic        v0;
  bike_tag_t   tag0;
  logic [31:0] lo0;
  logic [31:0] hi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag0.op  <= pair.op;
      tag0.inv <= (pair.first_property == 32'h0) || (pair.second_property == 32'h0);
      if (pair.first_property < pair.second_property) begin
        lo0 <= pair.first_property;
        hi0 <= pair.second_property;
      end else begin
        lo0 <= pair.second_property;
        hi0 <= pair.first_property;
      end
    end
  end

  // Ratio r = lo / hi in Q0.32; equal properties give exactly 1.0.
  logic            v1;
  logic [TAGW-1:0] side1;
  logic [QW-1:0]   q1;
  logic [QW-1:0]   r1;

  bike_fdiv #(.W(QW + 1), .SW(TAGW)) u_ratio (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v0), .in_side(tag0),
    .num({2'b00, lo0}), .den({2'b00, hi0}),
    .out_vld(v1), .out_side(side1), .q(q1)
  );

  assign r1 = q1[QW-1] ? ONE_Q32 : q1;

  // -log2(r).
  logic            v2;
  logic [TAGW-1:0] side2;
  logic [NLW-1:0]  nl2;
  bike_tag_t       tag2;

  bike_nlog #(.SW(TAGW)) u_log_r (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v1), .in_side(side1), .x(r1),
    .out_vld(v2), .out_side(side2), .nl(nl2)
  );

  assign tag2 = bike_tag_t'(side2);

  // Sixth root for Chueh-Prausnitz, square root for Gao: divide the log magnitude.
  logic            v3;
  logic [TAGW-1:0] side3;
  logic [NLW-1:0]  m3;

  bike_kdiv #(.SW(TAGW)) u_kdiv (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v2), .in_side(side2), .x(nl2), .sel6(tag2.op == OP_CP),
    .out_vld(v3), .out_side(side3), .q(m3)
  );

  // h = r^(1/k).
  logic            v4;
  logic [TAGW-1:0] side4;
  logic [QW-1:0]   h4;

  bike_exp2 #(.SW(TAGW)) u_root (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v3), .in_side(side3), .m(m3),
    .out_vld(v4), .out_side(side4), .p(h4)
  );

  // h^2, then numerator 2h and denominator 1 + h^2 of t = 2h / (1 + h^2).
  logic            v5;
  logic [TAGW-1:0] side5;
  logic [QW-1:0]   h5;
  logic [QW-1:0]   hsq5;
  logic [65:0]     hprod;

  assign hprod = 66'(h4) * 66'(h4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5 <= side4;
      h5    <= h4;
      hsq5  <= hprod[64:32];
    end
  end

  logic            v6;
  logic [TAGW-1:0] side6;
  logic [QW:0]     num6;
  logic [QW:0]     den6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side6 <= side5;
      num6  <= {h5, 1'b0};
      den6  <= {1'b0, ONE_Q32} + {1'b0, hsq5};
    end
  end

  // t, clamped to 1.0 when the numerator reaches the denominator.
  logic            v7;
  logic [TAGW-1:0] side7;
  logic [QW-1:0]   q7;
  logic [QW-1:0]   t7;

  bike_fdiv #(.W(QW + 1), .SW(TAGW)) u_tdiv (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v6), .in_side(side6), .num(num6), .den(den6),
    .out_vld(v7), .out_side(side7), .q(q7)
  );

  assign t7 = q7[QW-1] ? ONE_Q32 : q7;

  // Chueh-Prausnitz power t^3 in two multiply stages; it rides along the Gao path.
  logic            v8;
  logic [TAGW-1:0] side8;
  logic [QW-1:0]   t8;
  logic [QW-1:0]   tt8;
  logic [65:0]     tprod;

  assign tprod = 66'(t7) * 66'(t7);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side8 <= side7;
      t8    <= t7;
      tt8   <= tprod[64:32];
    end
  end

  logic            v9;
  logic [TAGW-1:0] side9;
  logic [QW-1:0]   t9;
  logic [QW-1:0]   c9;
  logic [65:0]     cprod;

  assign cprod = 66'(tt8) * 66'(t8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side9 <= side8;
      t9    <= t8;
      c9    <= cprod[64:32];
    end
  end

  // Gao power t^Z: -log2(t), scale by Z, then back through 2^-m.
  logic            v10;
  logic [SW2-1:0]  side10;
  logic [NLW-1:0]  nl10;

  bike_nlog #(.SW(SW2)) u_log_t (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v9), .in_side({side9, c9}), .x(t9),
    .out_vld(v10), .out_side(side10), .nl(nl10)
  );

  logic           v11;
  logic [SW2-1:0] side11;
  logic [36:0]    a11;
  logic [30:0]    b11;
  logic [62:0]    lprod;

  assign lprod = 63'(nl10[31:0]) * 63'(GAO_EXP_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (adv) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side11 <= side10;
      a11    <= 37'(nl10[NLW-1:32]) * 37'(GAO_EXP_Q32);
      b11    <= lprod[62:32];
    end
  end

  logic           v12;
  logic [SW2-1:0] side12;
  logic [QW-1:0]  pe12;
  bike_tag_t      tag12;
  logic [QW-1:0]  c12;

  bike_exp2 #(.SW(SW2)) u_pow (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(v11), .in_side(side11), .m(NLW'(a11) + NLW'(b11)),
    .out_vld(v12), .out_side(side12), .p(pe12)
  );

  assign tag12 = bike_tag_t'(side12[SW2-1 -: TAGW]);
  assign c12   = side12[QW-1:0];

  // Output register: kij = 1 - p, saturated below 1.0; a zero property forces zero.
  logic [QW-1:0] p12;
  logic [QW-1:0] diff12;
  logic [31:0]   kij12;

  always_comb begin
    p12    = (tag12.op == OP_GAO) ? pe12 : c12;
    diff12 = ONE_Q32 - p12;
    if (tag12.inv) begin
      kij12 = 32'h0;
    end else if (diff12[QW-1]) begin
      kij12 = 32'hFFFF_FFFF;
    end else begin
      kij12 = diff12[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.kij     <= kij12;
      result.invalid <= tag12.inv;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bike_fdiv.sv @@
// Pipelined restoring divider giving floor(num * 2^32 / den), one quotient bit per stage.
`default_nettype none

module bike_fdiv import bike_pkg::*; #(
  parameter int W  = 34,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [SW-1:0] in_side,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic          out_vld,
  output logic [SW-1:0] out_side,
  output logic [QW-1:0] q
);

  localparam int N = QW - 1;

  logic          vld  [0:N];
  logic [SW-1:0] side [0:N];
  logic [W-1:0]  rem  [0:N];
  logic [W-1:0]  dv   [0:N];
  logic [QW-1:0] qv   [0:N];

  logic ge0;
  assign ge0 = (num >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      dv[0]   <= den;
      rem[0]  <= ge0 ? W'(num - den) : num;
      qv[0]   <= {ge0, {N{1'b0}}};
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0]    sh;
    logic          ge;
    logic [QW-1:0] qn;

    always_comb begin
      sh        = {rem[k-1], 1'b0};
      ge        = (sh >= {1'b0, dv[k-1]});
      qn        = qv[k-1];
      qn[N-k]   = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
        dv[k]   <= dv[k-1];
        rem[k]  <= ge ? W'(sh - {1'b0, dv[k-1]}) : sh[W-1:0];
        qv[k]   <= qn;
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_side = side[N];
  assign q        = qv[N];

endmodule

`default_nettype wire

@@ rtl/bike_nlog.sv @@
// Pipelined -log2 of a Q0.32 value: staged normalization, then one squaring per stage.
`default_nettype none

module bike_nlog import bike_pkg::*; #(
  parameter int SW = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [SW-1:0]  in_side,
  input  logic [QW-1:0]  x,
  output logic           out_vld,
  output logic [SW-1:0]  out_side,
  output logic [NLW-1:0] nl
);

  localparam int NN   = 5;
  localparam int NS   = 32;
  localparam int LAST = NN + NS + 1;

  logic          vld  [0:LAST];
  logic [SW-1:0] side [0:LAST];
  logic          zf   [0:LAST-1];
  logic [5:0]    s    [0:LAST-1];
  logic [31:0]   z    [0:LAST-1];
  logic [31:0]   f    [0:LAST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  // Inputs of 1.0 and zero both give a log magnitude of zero.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      zf[0]   <= x[QW-1] | (x[31:0] == 32'h0);
      z[0]    <= x[31:0];
      s[0]    <= '0;
      f[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
      end
    end
  end

  for (genvar n = 1; n <= NN; n++) begin : g_norm
    localparam int A = 16 >> (n - 1);
    logic [31:0] zn;
    logic [5:0]  sn;

    always_comb begin
      if (z[n-1][31 -: A] == '0) begin
        zn = z[n-1] << A;
        sn = s[n-1] + 6'(A);
      end else begin
        zn = z[n-1];
        sn = s[n-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf[n] <= zf[n-1];
        z[n]  <= zn;
        s[n]  <= sn;
        f[n]  <= f[n-1];
      end
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_sq
    localparam int K = NN + j;
    logic [63:0] prod;
    logic [32:0] sq;
    logic [31:0] zn;
    logic [31:0] fn;

    always_comb begin
      prod = 64'(z[K-1]) * 64'(z[K-1]);
      sq   = prod[63:31];
      fn   = f[K-1];
      if (sq[32]) begin
        zn         = sq[32:1];
        fn[NS-j]   = 1'b1;
      end else begin
        zn = sq[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf[K] <= zf[K-1];
        z[K]  <= zn;
        s[K]  <= s[K-1];
        f[K]  <= fn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl <= zf[LAST-1] ? '0 : ({s[LAST-1] + 6'd1, 32'h0} - {6'h0, f[LAST-1]});
    end
  end

  assign out_vld  = vld[LAST];
  assign out_side = side[LAST];

endmodule

`default_nettype wire

@@ rtl/bike_kdiv.sv @@
// Pipelined division of a log magnitude by 6 or by 2, eight quotient bits per stage.
`default_nettype none

module bike_kdiv import bike_pkg::*; #(
  parameter int SW = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [SW-1:0]  in_side,
  input  logic [NLW-1:0] x,
  input  logic           sel6,
  output logic           out_vld,
  output logic [SW-1:0]  out_side,
  output logic [NLW-1:0] q
);

  localparam int XW   = 40;
  localparam int NB   = 8;
  localparam int NSTG = XW / NB;
  localparam logic [2:0] DIV_CP  = 3'd6;
  localparam logic [2:0] DIV_GAO = 3'd2;

  logic          vld  [0:NSTG];
  logic [SW-1:0] side [0:NSTG];
  logic [XW-1:0] w    [0:NSTG];
  logic [2:0]    r    [0:NSTG];
  logic          six  [0:NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      w[0]    <= {(XW - NLW)'(0), x};
      r[0]    <= '0;
      six[0]  <= sel6;
    end
  end

  // Quotient bits replace the dividend bits they were taken from.
  for (genvar j = 1; j <= NSTG; j++) begin : g_stg
    logic [2:0]    rr;
    logic [XW-1:0] ww;
    logic [2:0]    kk;
    logic [3:0]    t4;

    always_comb begin
      rr = r[j-1];
      ww = w[j-1];
      kk = six[j-1] ? DIV_CP : DIV_GAO;
      t4 = '0;
      for (int b = 0; b < NB; b++) begin
        t4 = {rr, ww[XW - 1 - NB * (j - 1) - b]};
        if (t4 >= {1'b0, kk}) begin
          rr                           = 3'(t4 - {1'b0, kk});
          ww[XW - 1 - NB * (j - 1) - b] = 1'b1;
        end else begin
          rr                           = t4[2:0];
          ww[XW - 1 - NB * (j - 1) - b] = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j] <= side[j-1];
        w[j]    <= ww;
        r[j]    <= rr;
        six[j]  <= six[j-1];
      end
    end
  end

  assign out_vld  = vld[NSTG];
  assign out_side = side[NSTG];
  assign q        = w[NSTG][NLW-1:0];

endmodule

`default_nettype wire

@@ rtl/bike_exp2.sv @@
// Pipelined 2^-m for a Q6.32 magnitude: one fraction bit and one root constant per stage.
`default_nettype none

module bike_exp2 import bike_pkg::*; #(
  parameter int SW = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [SW-1:0]  in_side,
  input  logic [NLW-1:0] m,
  output logic           out_vld,
  output logic [SW-1:0]  out_side,
  output logic [QW-1:0]  p
);

  localparam int NS   = 32;
  localparam int LAST = NS + 1;

  logic          vld  [0:LAST];
  logic [SW-1:0] side [0:LAST];
  logic          big  [0:NS];
  logic [5:0]    ip   [0:NS];
  logic [31:0]   fp   [0:NS];
  logic [QW-1:0] pv   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      big[0]  <= (m[NLW-1:32] > 6'd32);
      ip[0]   <= m[NLW-1:32];
      fp[0]   <= m[31:0];
      pv[0]   <= ONE_Q32;
    end
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
      end
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_mul
    localparam logic [31:0] D = bike_root(j);
    logic [64:0]   prod;
    logic [QW-1:0] pn;

    always_comb begin
      prod = 65'(pv[j-1]) * 65'(D);
      pn   = fp[j-1][NS-j] ? prod[64:32] : pv[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        big[j] <= big[j-1];
        ip[j]  <= ip[j-1];
        fp[j]  <= fp[j-1];
        pv[j]  <= pn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= big[NS] ? '0 : (pv[NS] >> ip[NS]);
    end
  end

  assign out_vld  = vld[LAST];
  assign out_side = side[LAST];

endmodule

`default_nettype wire

@@ rtl/bike_checker.sv @@
// Port-level checks of the kij estimator and their binding to the top level.
`default_nettype none

module bike_checker (
  input logic        clk,
  input logic        rst,
  input logic        pair_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_kij,
  input logic        result_invalid
);

  // A flagged result always carries a zero kij.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_invalid |-> result_kij == 32'h0)
    else $error("invalid result with nonzero kij");

  // An empty output stage never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pair_ready)
    else $error("input stalled while output is empty");

  // A result that is not taken stays, unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_kij)
      && $stable(result_invalid))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind binary_interaction_kij_estimator_core bike_checker u_bike_checker (
  .clk(clk),
  .rst(rst),
  .pair_ready(pair.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_kij(result.kij),
  .result_invalid(result.invalid)
);

`default_nettype wire

@@ tb/binary_interaction_kij_estimator_core_tb.sv @@
// Self-checking testbench of the kij estimator core with a built-in fixed-point predictor.
`default_nettype none

module binary_interaction_kij_estimator_core_tb;
  import bike_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int LATENCY     = 225;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 300000;

  // One expected result for a pair that has been taken in.
  typedef struct {
    logic [31:0] kij;
    logic        invalid;
  } kij_result_t;

  // Scoreboard: works out kij for every accepted pair and checks results in order.
  class kij_board;
    kij_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      v   = x;
      res = '0;
      bt  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    // floor(num * 2^32 / den) by restoring long division.
    function logic [63:0] ratio_q32(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = num / den;
      rem = num % den;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= den) begin
          rem  = rem - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    // -log2(x) for x in Q0.32, result Q32.32.
    function logic [63:0] minus_log2(logic [63:0] x);
      logic [63:0] z;
      logic [63:0] s;
      logic [63:0] f;
      z = x;
      s = 0;
      f = 0;
      if (x >= 64'h1_0000_0000 || x == 0) return 0;
      while (z < 64'h8000_0000) begin
        z = z << 1;
        s++;
      end
      s++;
      for (int i = 31; i >= 0; i--) begin
        z = (z * z) >> 31;
        if (z >= 64'h1_0000_0000) begin
          z    = z >> 1;
          f[i] = 1'b1;
        end
      end
      return (s << 32) - f;
    endfunction

    // 2^-m for m in Q32.32, result Q0.32.
    function logic [63:0] pow2_neg(logic [63:0] m);
      logic [63:0] p;
      logic [63:0] d;
      p = 64'h1_0000_0000;
      d = 64'h8000_0000;
      if ((m >> 32) > 32) return 0;
      for (int i = 31; i >= 0; i--) begin
        d = int_sqrt(d << 32);
        if (m[i]) p = (p * d) >> 32;
      end
      return p >> (m >> 32);
    endfunction

    function void note(logic op, logic [31:0] a, logic [31:0] b);
      kij_result_t e;
      logic [63:0] lo, hi, r, h, t, p, den, nl, sc;
      if (a == 0 || b == 0) begin
        e.kij     = '0;
        e.invalid = 1'b1;
      end else begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        r  = ratio_q32(lo, hi);
        h  = pow2_neg(minus_log2(r) / ((op == OP_GAO) ? 2 : 6));
        if (h >= 64'h1_0000_0000) begin
          t = 64'h1_0000_0000;
        end else begin
          den = 64'h1_0000_0000 + ((h * h) >> 32);
          t   = (2 * h >= den) ? 64'h1_0000_0000 : ratio_q32(2 * h, den);
        end
        if (op == OP_CP) begin
          if (t >= 64'h1_0000_0000) begin
            p = 64'h1_0000_0000;
          end else begin
            p = (t * t) >> 32;
            p = (p * t) >> 32;
          end
        end else begin
          nl = minus_log2(t);
          sc = (nl >> 32) * GAO_EXP_Q32 + (((nl & 64'hFFFF_FFFF) * GAO_EXP_Q32) >> 32);
          p  = pow2_neg(sc);
        end
        p         = 64'h1_0000_0000 - p;
        e.kij     = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
        e.invalid = 1'b0;
      end
      pending.push_back(e);
    endfunction

    function void check(logic [31:0] kij, logic invalid);
      kij_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kij=%h invalid=%b", $time, kij, invalid);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kij !== e.kij) begin
        $display("%0t: kij mismatch expected %h actual %h", $time, e.kij, kij);
        errors++;
      end
      if (invalid !== e.invalid) begin
        $display("%0t: invalid mismatch expected %b actual %b", $time, e.invalid, invalid);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bike_pair_if   pair ();
  bike_result_if result ();

  binary_interaction_kij_estimator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair),
    .result (result)
  );

  kij_board board;
  int       cycles = 0;
  // Receiver control: a long hold-off request, and the quiet closing stretch.
  logic     hold_request;
  logic     quiet;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  initial begin
    board           = new();
    rst             = 1'b1;
    pair.valid      = 1'b0;
    pair.op         = OP_CP;
    pair.first_property  = '0;
    pair.second_property = '0;
    result.ready    = 1'b0;
    hold_request    = 1'b0;
    quiet           = 1'b0;
  end

  // Every transfer on either side is seen here, at the rising edge, after
  // the inputs have settled at the preceding falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (pair.valid && pair.ready) begin
        board.note(pair.op, pair.first_property, pair.second_property);
      end
      if (result.valid && result.ready) begin
        board.check(result.kij, result.invalid);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("binary_interaction_kij_estimator_core_tb NOT OK");
      $finish;
    end
  end

  // The result side stalls in random bursts. On request it holds off for a
  // long, counted stretch so that the whole pipeline backs up, and in the
  // closing stretch it takes every result at once.
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_request) begin
        result.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        result.ready = 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end else begin
        result.ready = 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Offer one pair and hold it until the block takes it.
  task automatic send_pair(logic op, logic [31:0] a, logic [31:0] b);
    @(negedge clk);
    pair.valid           = 1'b1;
    pair.op              = op;
    pair.first_property  = a;
    pair.second_property = b;
    do @(posedge clk); while (!pair.ready);
  endtask

  // Sometimes leave the input idle for a random burst before the next pair.
  task automatic maybe_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      pair.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // A property drawn from several shapes: full range, small, large, mid range,
  // or close to a given partner so that the ratio sits near one.
  function automatic logic [31:0] pick_property(logic [31:0] partner);
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      2: return partner + $urandom_range(0, 64) - 32;
      3: return (($urandom_range(1, 400)) << 16) | $urandom_range(0, 32'hFFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_pair(bit zero_noise);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom();
    if ($urandom_range(0, 1)) a = pick_property(a);
    b = pick_property(a);
    // A few pairs carry a zero property to exercise the invalid flag.
    if (zero_noise && $urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) a = '0; else b = '0;
    end
    send_pair(1'($urandom_range(0, 1)), a, b);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] dir_a[12];
    logic [31:0] dir_b[12];
    dir_a = '{32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1,
              32'hFFFF_FFFF, 32'h0064_0000, 32'h0064_0000, 32'h8000_0000,
              32'h0000_0002, 32'h0012_3456};
    dir_b = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h1, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0064_0001, 32'h00C8_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h0034_5678};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pairs: zero properties, equal properties, the most extreme
    // ratios, ratios near one and two moderate ratios, in both correlations.
    for (int k = 0; k < 12; k++) begin
      send_pair(OP_CP, dir_a[k], dir_b[k]);
      maybe_gap();
      send_pair(OP_GAO, dir_a[k], dir_b[k]);
      maybe_gap();
    end

    // Random pairs with idling on both sides.
    for (int k = 0; k < 500; k++) begin
      random_pair(1'b1);
      maybe_gap();
    end

    // Long hold-off on the result side while pairs keep coming, so that the
    // pipeline fills and stalls its input.
    hold_request = 1'b1;
    for (int k = 0; k < 300; k++) begin
      random_pair(1'b1);
    end

    // Pause the input until every expected result is back.
    @(negedge clk);
    pair.valid = 1'b0;
    drain();

    for (int k = 0; k < 180; k++) begin
      random_pair(1'b1);
      maybe_gap();
    end

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    for (int k = 0; k < 150; k++) begin
      random_pair(1'b1);
    end
    @(negedge clk);
    pair.valid = 1'b0;

    drain();
    repeat (LATENCY + 25) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("binary_interaction_kij_estimator_core_tb OK");
    end else begin
      $display("binary_interaction_kij_estimator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bike_pkg.sv
rtl/bike_if.sv
rtl/bike_fdiv.sv
rtl/bike_nlog.sv
rtl/bike_kdiv.sv
rtl/bike_exp2.sv
rtl/binary_interaction_kij_estimator_core.sv
rtl/bike_checker.sv
tb/binary_interaction_kij_estimator_core_tb.sv
